>>> src/prs_pkg.sv
// Shared constants, register indexes and types for the power rail supervisor.
`timescale 1ns / 1ps

package prs_pkg;

    // sample store and timing
    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int TICK_PERIOD  = 1000;
    localparam int TICK_W       = $clog2(TICK_PERIOD + 1);
    localparam int HB_DIV       = 500;
    localparam int HB_W         = $clog2(HB_DIV);
    localparam int BLINK_DIV    = 100;
    localparam int BLINK_W      = $clog2(BLINK_DIV);

    // channels that carry the rails
    localparam int MAIN_CH  = 0;
    localparam int AUX_CH   = 2;
    localparam int INPUT_CH = 4;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 20;
    localparam int VOLT_W   = 16;
    localparam int TOL_W    = 16;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;

    // 12 V in Q8.8
    localparam logic [11:0] NOMINAL_Q88 = 12'd3072;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_ENABLED = 3'd6;

    // input kind
    localparam logic OP_ADC  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // LED bit positions
    localparam int LED_HB    = 0;
    localparam int LED_FAULT = 1;
    localparam int LED_MAIN  = 2;
    localparam int LED_AUX   = 3;

    // result word, last member in the lowest bits (matches m_tdata packing)
    typedef struct packed {
        logic [7:0] input_volts;
        logic [7:0] aux_volts;
        logic [7:0] main_volts;
        logic       input_flt;
        logic       aux_flt;
        logic       main_flt;
        logic       any_fault;
        logic       aux_led;
        logic       main_led;
        logic       fault_led;
        logic       heartbeat_led;
    } result_t;

endpackage

>>> src/power_rail_supervisor.sv
// Power rail supervisor: sample store, rail scaling, window checks and LED/telemetry ticks.
`timescale 1ns / 1ps

// Usage:
//  s_* channel takes one word per event. s_tuser = 0 is an ADC conversion
//  (s_tdata holds the sample and the end-of-conversion flag, s_tlast marks end
//  of sequence, which rescales the rails); s_tuser = 1 is a millisecond tick.
//  Every accepted word yields exactly one result word on m_*: LED levels and
//  fault flags in m_tdata[7:0], whole-volt telemetry in m_tdata[31:8];
//  m_tuser is high on ticks that carry a telemetry frame.
//  Results leave from a result register. Throughput is one word per cycle while
//  the receiver keeps m_tready high, set by the single-pass scale/compare
//  datapath between the state registers and the result register.
//  A two-entry output stage (result register plus skid register) lets one more
//  word in while the receiver stalls; s_tready drops only when both are full.
//  Configuration is written through cfg_we/cfg_index/cfg_data; the user must
//  write it only while idle, which the block itself does not enforce. Synchronous
//  active-low reset loads the register defaults, clears the sample store,
//  channel index, voltages, tick counters and LEDs, and empties the output stage.
module power_rail_supervisor (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prs_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_sample, [12] end_of_conversion, rest zero
    input  logic        s_tuser,   // op
    input  logic        s_tlast,   // end_of_sequence
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // heartbeat_led, fault_led, main_led, aux_led, any_fault,
                                   // main_flt, aux_flt, input_flt, main_volts[15:8],
                                   // aux_volts[23:16], input_volts[31:24]
    output logic        m_tuser    // telemetry_valid
);

    // configuration registers
    logic [prs_pkg::GAIN_W-1:0] main_gain_reg, aux_gain_reg, input_gain_reg;
    logic [prs_pkg::TOL_W-1:0]  tolerance_reg;
    logic [prs_pkg::VOLT_W-1:0] input_low_reg, input_high_reg;
    logic                       main_enabled_reg;

    // datapath state
    logic [prs_pkg::SAMPLE_W-1:0] store_reg [prs_pkg::NUM_CHANNELS];
    logic [prs_pkg::SAMPLE_W-1:0] store_next [prs_pkg::NUM_CHANNELS];
    logic [prs_pkg::CH_W-1:0]     chan_reg, chan_next;
    logic [prs_pkg::VOLT_W-1:0]   main_v_reg, main_v_next;
    logic [prs_pkg::VOLT_W-1:0]   aux_v_reg, aux_v_next;
    logic [prs_pkg::VOLT_W-1:0]   input_v_reg, input_v_next;
    logic [prs_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [prs_pkg::HB_W-1:0]     hb_reg, hb_next;
    logic [prs_pkg::BLINK_W-1:0]  blink_reg, blink_next;
    logic [3:0]                   led_reg, led_next;

    // output stage
    prs_pkg::result_t out_reg, out_next, skid_reg, skid_next, res;
    logic             out_tele_reg, out_tele_next, skid_tele_reg, skid_tele_next, res_tele;
    logic             out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    // input fields
    logic                         in_op, in_eoc, in_eos, accept;
    logic [prs_pkg::SAMPLE_W-1:0] in_sample;

    // window limits, v << 16 compared against 3072 * (65536 -/+ tol)
    logic [16:0] frac_lo, frac_hi;
    logic [31:0] lim_lo, lim_hi;
    logic        mf, af, inf, anyf;

    // tick bookkeeping
    logic [prs_pkg::TICK_W-1:0]  tick_eff;
    logic [prs_pkg::HB_W-1:0]    hb_eff;
    logic [prs_pkg::BLINK_W-1:0] blink_eff;
    logic                        wrap, hb_hit, blink_hit;

    assign in_op     = s_tuser;
    assign in_sample = s_tdata[11:0];
    assign in_eoc    = s_tdata[12];
    assign in_eos    = s_tlast;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = out_tele_reg;

    assign frac_lo = 17'h10000 - {1'b0, tolerance_reg};
    assign frac_hi = 17'h10000 + {1'b0, tolerance_reg};
    assign lim_lo  = 32'(frac_lo) * 32'(prs_pkg::NOMINAL_Q88);
    assign lim_hi  = 32'(frac_hi) * 32'(prs_pkg::NOMINAL_Q88);

    function automatic logic [prs_pkg::VOLT_W-1:0] scale(
        input logic [prs_pkg::SAMPLE_W-1:0] sample,
        input logic [prs_pkg::GAIN_W-1:0]   gain
    );
        logic [31:0] prod;
        prod = 32'(sample) * 32'(gain);
        return prod[31:16];
    endfunction

    // ADC side: store, then rescale (a stored sample is visible to the rescale)
    always_comb begin
        store_next   = store_reg;
        chan_next    = chan_reg;
        main_v_next  = main_v_reg;
        aux_v_next   = aux_v_reg;
        input_v_next = input_v_reg;
        if (accept && in_op == prs_pkg::OP_ADC) begin
            if (in_eoc) begin
                store_next[chan_reg] = in_sample;
                if (chan_reg == prs_pkg::CH_W'(prs_pkg::NUM_CHANNELS - 1)) begin
                    chan_next = '0;
                end else begin
                    chan_next = chan_reg + 1'b1;
                end
            end
            if (in_eos) begin
                main_v_next  = scale(store_next[prs_pkg::MAIN_CH], main_gain_reg);
                aux_v_next   = scale(store_next[prs_pkg::AUX_CH], aux_gain_reg);
                input_v_next = scale(store_next[prs_pkg::INPUT_CH], input_gain_reg);
                chan_next    = '0;
            end
        end
    end

    // faults from the voltages as they stand after this word
    always_comb begin
        mf = (main_enabled_reg && ({main_v_next, 16'h0} < lim_lo))
             || ({main_v_next, 16'h0} > lim_hi);
        af = ({aux_v_next, 16'h0} < lim_lo) || ({aux_v_next, 16'h0} > lim_hi);
        inf = (input_v_next > input_high_reg) || (input_v_next < input_low_reg);
        anyf = mf || af || inf;
    end

    // tick side; phase counters track tick % 500 and tick % 100
    always_comb begin
        wrap      = tick_reg >= prs_pkg::TICK_W'(prs_pkg::TICK_PERIOD);
        tick_eff  = wrap ? '0 : tick_reg;
        hb_eff    = wrap ? '0 : hb_reg;
        blink_eff = wrap ? '0 : blink_reg;
        hb_hit    = hb_eff == '0;
        blink_hit = blink_eff == '0;
        tick_next  = tick_reg;
        hb_next    = hb_reg;
        blink_next = blink_reg;
        led_next   = led_reg;
        res_tele   = 1'b0;
        if (accept && in_op == prs_pkg::OP_TICK) begin
            if (hb_hit) begin
                led_next[prs_pkg::LED_HB] = !led_next[prs_pkg::LED_HB];
            end
            if (blink_hit) begin
                if (anyf) begin
                    led_next[prs_pkg::LED_FAULT] = !led_next[prs_pkg::LED_FAULT];
                    if (mf) begin
                        led_next[prs_pkg::LED_MAIN] = !led_next[prs_pkg::LED_MAIN];
                    end
                    if (af) begin
                        led_next[prs_pkg::LED_AUX] = !led_next[prs_pkg::LED_AUX];
                    end
                end else begin
                    led_next[prs_pkg::LED_FAULT] = 1'b0;
                end
                res_tele = 1'b1;
            end
            if (!mf) begin
                led_next[prs_pkg::LED_MAIN] = 1'b0;
            end
            if (!af) begin
                led_next[prs_pkg::LED_AUX] = 1'b1;
            end
            tick_next = tick_eff + 1'b1;
            if (hb_eff == prs_pkg::HB_W'(prs_pkg::HB_DIV - 1)) begin
                hb_next = '0;
            end else begin
                hb_next = hb_eff + 1'b1;
            end
            if (blink_eff == prs_pkg::BLINK_W'(prs_pkg::BLINK_DIV - 1)) begin
                blink_next = '0;
            end else begin
                blink_next = blink_eff + 1'b1;
            end
        end
    end

    // result word
    always_comb begin
        res.heartbeat_led = led_next[prs_pkg::LED_HB];
        res.fault_led     = led_next[prs_pkg::LED_FAULT];
        res.main_led      = led_next[prs_pkg::LED_MAIN];
        res.aux_led       = led_next[prs_pkg::LED_AUX];
        res.any_fault     = anyf;
        res.main_flt      = mf;
        res.aux_flt       = af;
        res.input_flt     = inf;
        res.main_volts    = res_tele ? main_v_next[15:8] : 8'h0;
        res.aux_volts     = res_tele ? aux_v_next[15:8] : 8'h0;
        res.input_volts   = res_tele ? input_v_next[15:8] : 8'h0;
    end

    // output register plus skid
    always_comb begin
        out_next        = out_reg;
        out_tele_next   = out_tele_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_tele_next  = skid_tele_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !m_tready) begin
            if (accept) begin
                skid_next       = res;
                skid_tele_next  = res_tele;
                skid_valid_next = 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_next        = skid_reg;
            out_tele_next   = skid_tele_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end else begin
            out_next       = res;
            out_tele_next  = res_tele;
            out_valid_next = accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_gain_reg    <= 20'd88080;
            aux_gain_reg     <= 20'd88080;
            input_gain_reg   <= 20'd507900;
            tolerance_reg    <= 16'd6554;
            input_low_reg    <= 16'd9984;
            input_high_reg   <= 16'd11520;
            main_enabled_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                prs_pkg::CFG_MAIN_GAIN:    main_gain_reg    <= cfg_data;
                prs_pkg::CFG_AUX_GAIN:     aux_gain_reg     <= cfg_data;
                prs_pkg::CFG_INPUT_GAIN:   input_gain_reg   <= cfg_data;
                prs_pkg::CFG_TOLERANCE:    tolerance_reg    <= cfg_data[15:0];
                prs_pkg::CFG_INPUT_LOW:    input_low_reg    <= cfg_data[15:0];
                prs_pkg::CFG_INPUT_HIGH:   input_high_reg   <= cfg_data[15:0];
                prs_pkg::CFG_MAIN_ENABLED: main_enabled_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < prs_pkg::NUM_CHANNELS; i++) begin
                store_reg[i] <= '0;
            end
            chan_reg       <= '0;
            main_v_reg     <= '0;
            aux_v_reg      <= '0;
            input_v_reg    <= '0;
            tick_reg       <= '0;
            hb_reg         <= '0;
            blink_reg      <= '0;
            led_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            store_reg      <= store_next;
            chan_reg       <= chan_next;
            main_v_reg     <= main_v_next;
            aux_v_reg      <= aux_v_next;
            input_v_reg    <= input_v_next;
            tick_reg       <= tick_next;
            hb_reg         <= hb_next;
            blink_reg      <= blink_next;
            led_reg        <= led_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        out_reg       <= out_next;
        out_tele_reg  <= out_tele_next;
        skid_reg      <= skid_next;
        skid_tele_reg <= skid_tele_next;
    end

endmodule

>>> src/prs_checker.sv
// Port-level assertions for the power rail supervisor, bound to the top level.
`timescale 1ns / 1ps

module prs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // m_tvalid is high on the next cycle after every accepted word
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted word produced no result");

    // telemetry bytes are zero unless a frame is flagged
    a_tele_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[31:8] == 24'h0))
        else $error("volts present without telemetry flag");

    // summary fault is the OR of the rail faults
    a_any_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4] == (m_tdata[5] | m_tdata[6] | m_tdata[7])))
        else $error("any_fault disagrees with rail faults");

    // stalled result holds its word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind power_rail_supervisor prs_checker u_prs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
